/* hw/rtl/sdspi_pkg.sv */
// Shared types and constants for the SD card SPI-mode command sequencer.
`default_nettype none

package sdspi_pkg;

  // Data bytes in one card block and wake-up bytes sent before CMD0
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned WAKE_BYTES  = 10;

  // Byte counter width: enough to count the longest run of bytes
  localparam int unsigned CNT_W =
    $clog2((BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES);

  // Fixed frame lengths
  localparam int unsigned CMD_FRAME_BYTES = 7;
  localparam int unsigned R7_TAIL_BYTES   = 4;
  localparam int unsigned OCR_TAIL_BYTES  = 4;
  localparam int unsigned RD_DUMMY_BYTES  = 3;
  localparam int unsigned WR_CRC_BYTES    = 2;
  localparam int unsigned WR_TAIL_BYTES   = 2;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // Command opcodes (start bit plus command index)
  localparam logic [7:0] OP_GO_IDLE = 8'h40;
  localparam logic [7:0] OP_IF_COND = 8'h48;
  localparam logic [7:0] OP_READ    = 8'h51;
  localparam logic [7:0] OP_WRITE   = 8'h58;
  localparam logic [7:0] OP_APP_OP  = 8'h69;
  localparam logic [7:0] OP_APP     = 8'h77;
  localparam logic [7:0] OP_OCR     = 8'h7A;

  // Command CRC bytes and arguments
  localparam logic [7:0]  CRC_GO_IDLE = 8'h95;
  localparam logic [7:0]  CRC_IF_COND = 8'h87;
  localparam logic [7:0]  CRC_APP     = 8'h65;
  localparam logic [7:0]  CRC_APP_OP2 = 8'h77;
  localparam logic [7:0]  CRC_NONE    = 8'hFF;
  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

  // Card bytes
  localparam logic [7:0] BYTE_IDLE_FILL = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN     = 8'hFE;
  localparam logic [7:0] BYTE_R1_IDLE   = 8'h01;
  localparam logic [7:0] BYTE_R1_READY  = 8'h00;
  localparam logic [7:0] BYTE_ECHO      = 8'hAA;
  localparam logic [7:0] BYTE_BUSY      = 8'h00;
  localparam logic [7:0] R1_ILLEGAL     = 8'h04;
  localparam logic [7:0] OCR_CCS_MASK   = 8'hC0;
  localparam logic [4:0] DATA_ACCEPTED  = 5'h05;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_READ     = 2'd1,
    MODE_WRITE    = 2'd2,
    MODE_EXCHANGE = 2'd3
  } mode_e;

  // Sequencer phases, one-hot
  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_WAKE     = 16'h0002,
    PH_CMD_TX   = 16'h0004,
    PH_CMD_POLL = 16'h0008,
    PH_R7_TAIL  = 16'h0010,
    PH_OCR_TAIL = 16'h0020,
    PH_RD_TOKEN = 16'h0040,
    PH_RD_DATA  = 16'h0080,
    PH_RD_DUMMY = 16'h0100,
    PH_WR_PRE   = 16'h0200,
    PH_WR_TOKEN = 16'h0400,
    PH_WR_DATA  = 16'h0800,
    PH_WR_CRC   = 16'h1000,
    PH_WR_RESP  = 16'h2000,
    PH_WR_BUSY  = 16'h4000,
    PH_WR_TAIL  = 16'h8000
  } phase_e;

  // One result item
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_active;
    logic       fast_clock;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic       failed;
    logic       high_capacity;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sd_spi_command_sequencer.sv */
// SD card SPI-mode command sequencer: init, single-block read and write.
`default_nettype none

// Byte-level SD card master for SPI mode. Each input transaction is either a
// request (tuser: init, block read, block write) or the report of one finished
// SPI byte exchange (tuser 3) with the byte received from the card. Each input
// transaction yields exactly one output transaction telling the byte to shift
// out next (send_valid), chip select and clock speed for that exchange, a read
// block byte when one was just received, and done/failed at the end of an
// operation (done travels as tlast). Requests while busy and exchange reports
// while idle are ignored but still answered. One transaction is accepted per
// clock while the skid entry is empty; each result is registered before it
// reaches the output, and a two-entry output buffer keeps input accepting
// while one result waits for the consumer.
module sd_spi_command_sequencer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: block_address [31:0], received_byte [39:32], write_data [47:40]
  input  wire  [sdspi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode [1:0]
  input  wire  [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: send_valid [0], send_byte [8:1], select_active [9], fast_clock [10],
  //        read_valid [11], read_data [19:12], failed [20],
  //        high_capacity [21], zero [23:22]
  output logic [sdspi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: done_res
  output logic                             m_axis_tlast
);
  import sdspi_pkg::*;

  // Input fields
  mode_e       mode;
  logic [31:0] block_address;
  logic [7:0]  received_byte;
  logic [7:0]  write_data;

  // Sequencer state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic [7:0]       opcode_q, opcode_d;
  logic [31:0]      argument_q, argument_d;
  logic [7:0]       crc_q, crc_d;
  logic             version_two_q, version_two_d;
  logic             capacity_q, capacity_d;
  logic             select_q, select_d;
  logic             clock_fast_q, clock_fast_d;
  logic [7:0]       ocr_top_q, ocr_top_d;

  // Per-item outputs
  logic       acted;
  logic       rd_valid;
  logic       op_done;
  logic       op_failed;
  logic [7:0] emit_byte;
  result_t    res;

  // Output buffer
  result_t out_q, out_d;
  result_t skid_q;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    in_fire, out_fire, load_out, load_skid;

  assign mode          = mode_e'(s_axis_tuser);
  assign block_address = s_axis_tdata[31:0];
  assign received_byte = s_axis_tdata[39:32];
  assign write_data    = s_axis_tdata[47:40];

  assign s_axis_tready = ~skid_valid_q;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;

  // Advance the sequencer by one transaction
  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    opcode_d      = opcode_q;
    argument_d    = argument_q;
    crc_d         = crc_q;
    version_two_d = version_two_q;
    capacity_d    = capacity_q;
    select_d      = select_q;
    clock_fast_d  = clock_fast_q;
    ocr_top_d     = ocr_top_q;
    acted         = 1'b0;
    rd_valid      = 1'b0;
    op_done       = 1'b0;
    op_failed     = 1'b0;

    if (phase_q == PH_IDLE) begin
      case (mode)
        MODE_INIT: begin
          version_two_d = 1'b0;
          capacity_d    = 1'b0;
          clock_fast_d  = 1'b0;
          select_d      = 1'b0;
          phase_d       = PH_WAKE;
          byte_count_d  = '0;
          acted         = 1'b1;
        end
        MODE_READ, MODE_WRITE: begin
          select_d     = 1'b1;
          opcode_d     = (mode == MODE_READ) ? OP_READ : OP_WRITE;
          argument_d   = capacity_q ? block_address : {block_address[22:0], 9'd0};
          crc_d        = CRC_NONE;
          phase_d      = PH_CMD_TX;
          byte_count_d = '0;
          acted        = 1'b1;
        end
        default: begin
          acted = 1'b0;
        end
      endcase
    end else if (mode == MODE_EXCHANGE) begin
      acted = 1'b1;
      case (phase_q)
        PH_WAKE: begin
          if (byte_count_q == CNT_W'(WAKE_BYTES - 1)) begin
            select_d     = 1'b1;
            opcode_d     = OP_GO_IDLE;
            argument_d   = '0;
            crc_d        = CRC_GO_IDLE;
            phase_d      = PH_CMD_TX;
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_CMD_TX: begin
          if (byte_count_q == CNT_W'(CMD_FRAME_BYTES - 1)) begin
            phase_d      = PH_CMD_POLL;
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_CMD_POLL: begin
          if (received_byte != BYTE_IDLE_FILL) begin
            // Dispatch on the reply to the command just sent
            case (opcode_q)
              OP_GO_IDLE: begin
                if (received_byte == BYTE_R1_IDLE) begin
                  opcode_d     = OP_IF_COND;
                  argument_d   = ARG_IF_COND;
                  crc_d        = CRC_IF_COND;
                  phase_d      = PH_CMD_TX;
                  byte_count_d = '0;
                end else begin
                  select_d     = 1'b0;
                  phase_d      = PH_WAKE;
                  byte_count_d = '0;
                end
              end
              OP_IF_COND: begin
                if ((received_byte & R1_ILLEGAL) != 8'h00) begin
                  version_two_d = 1'b0;
                  opcode_d      = OP_APP;
                  argument_d    = '0;
                  crc_d         = CRC_APP;
                  phase_d       = PH_CMD_TX;
                  byte_count_d  = '0;
                end else begin
                  phase_d      = PH_R7_TAIL;
                  byte_count_d = '0;
                end
              end
              OP_APP: begin
                opcode_d     = OP_APP_OP;
                argument_d   = version_two_q ? ARG_HCS : 32'd0;
                crc_d        = version_two_q ? CRC_APP_OP2 : CRC_NONE;
                phase_d      = PH_CMD_TX;
                byte_count_d = '0;
              end
              OP_APP_OP: begin
                if (received_byte != BYTE_R1_READY) begin
                  opcode_d     = OP_APP;
                  argument_d   = '0;
                  crc_d        = CRC_APP;
                  phase_d      = PH_CMD_TX;
                  byte_count_d = '0;
                end else if (version_two_q) begin
                  opcode_d     = OP_OCR;
                  argument_d   = '0;
                  crc_d        = CRC_NONE;
                  phase_d      = PH_CMD_TX;
                  byte_count_d = '0;
                end else begin
                  clock_fast_d = 1'b1;
                  phase_d      = PH_IDLE;
                  byte_count_d = '0;
                  select_d     = 1'b0;
                  op_done      = 1'b1;
                end
              end
              OP_OCR: begin
                phase_d      = PH_OCR_TAIL;
                byte_count_d = '0;
                if (received_byte != BYTE_R1_READY) begin
                  phase_d   = PH_IDLE;
                  select_d  = 1'b0;
                  op_done   = 1'b1;
                  op_failed = 1'b1;
                end
              end
              OP_READ: begin
                phase_d = PH_RD_TOKEN;
                if (received_byte != BYTE_R1_READY) begin
                  phase_d      = PH_IDLE;
                  byte_count_d = '0;
                  select_d     = 1'b0;
                  op_done      = 1'b1;
                  op_failed    = 1'b1;
                end
              end
              OP_WRITE: begin
                phase_d = PH_WR_PRE;
                if (received_byte != BYTE_R1_READY) begin
                  phase_d      = PH_IDLE;
                  byte_count_d = '0;
                  select_d     = 1'b0;
                  op_done      = 1'b1;
                  op_failed    = 1'b1;
                end
              end
              default: begin
                phase_d      = PH_IDLE;
                byte_count_d = '0;
                select_d     = 1'b0;
                op_done      = 1'b1;
                op_failed    = 1'b1;
              end
            endcase
          end
        end
        PH_R7_TAIL: begin
          if (byte_count_q == CNT_W'(R7_TAIL_BYTES - 1)) begin
            if (received_byte != BYTE_ECHO) begin
              phase_d      = PH_IDLE;
              byte_count_d = '0;
              select_d     = 1'b0;
              op_done      = 1'b1;
              op_failed    = 1'b1;
            end else begin
              version_two_d = 1'b1;
              opcode_d      = OP_APP;
              argument_d    = '0;
              crc_d         = CRC_APP;
              phase_d       = PH_CMD_TX;
              byte_count_d  = '0;
            end
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_OCR_TAIL: begin
          // Keep the top OCR byte; decide capacity on the last byte
          if (byte_count_q == '0) begin
            ocr_top_d = received_byte;
          end
          if (byte_count_q == CNT_W'(OCR_TAIL_BYTES - 1)) begin
            capacity_d   = ((ocr_top_q & OCR_CCS_MASK) == OCR_CCS_MASK);
            clock_fast_d = 1'b1;
            phase_d      = PH_IDLE;
            byte_count_d = '0;
            select_d     = 1'b0;
            op_done      = 1'b1;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_RD_TOKEN: begin
          if (received_byte == BYTE_TOKEN) begin
            phase_d      = PH_RD_DATA;
            byte_count_d = '0;
          end
        end
        PH_RD_DATA: begin
          rd_valid = 1'b1;
          if (byte_count_q == CNT_W'(BLOCK_BYTES - 1)) begin
            phase_d      = PH_RD_DUMMY;
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_RD_DUMMY: begin
          if (byte_count_q == CNT_W'(RD_DUMMY_BYTES - 1)) begin
            phase_d      = PH_IDLE;
            byte_count_d = '0;
            select_d     = 1'b0;
            op_done      = 1'b1;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_WR_PRE: begin
          phase_d = PH_WR_TOKEN;
        end
        PH_WR_TOKEN: begin
          phase_d      = PH_WR_DATA;
          byte_count_d = '0;
        end
        PH_WR_DATA: begin
          if (byte_count_q == CNT_W'(BLOCK_BYTES - 1)) begin
            phase_d      = PH_WR_CRC;
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_WR_CRC: begin
          if (byte_count_q == CNT_W'(WR_CRC_BYTES - 1)) begin
            phase_d      = PH_WR_RESP;
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        PH_WR_RESP: begin
          if (received_byte[4:0] == DATA_ACCEPTED) begin
            phase_d = PH_WR_BUSY;
          end
        end
        PH_WR_BUSY: begin
          if (received_byte != BYTE_BUSY) begin
            phase_d      = PH_WR_TAIL;
            byte_count_d = '0;
          end
        end
        PH_WR_TAIL: begin
          if (byte_count_q == CNT_W'(WR_TAIL_BYTES - 1)) begin
            phase_d      = PH_IDLE;
            byte_count_d = '0;
            select_d     = 1'b0;
            op_done      = 1'b1;
          end else begin
            byte_count_d = byte_count_q + 1'b1;
          end
        end
        default: begin
          phase_d      = PH_IDLE;
          byte_count_d = '0;
          select_d     = 1'b0;
          op_done      = 1'b1;
          op_failed    = 1'b1;
        end
      endcase
    end
  end

  // Select the byte due on the next exchange
  always_comb begin
    case (phase_d)
      PH_CMD_TX: begin
        case (byte_count_d)
          CNT_W'(0): emit_byte = BYTE_IDLE_FILL;
          CNT_W'(1): emit_byte = opcode_d;
          CNT_W'(2): emit_byte = argument_d[31:24];
          CNT_W'(3): emit_byte = argument_d[23:16];
          CNT_W'(4): emit_byte = argument_d[15:8];
          CNT_W'(5): emit_byte = argument_d[7:0];
          default:   emit_byte = crc_d;
        endcase
      end
      PH_WR_TOKEN: emit_byte = BYTE_TOKEN;
      PH_WR_DATA:  emit_byte = write_data;
      default:     emit_byte = BYTE_IDLE_FILL;
    endcase
  end

  // Assemble the result item
  always_comb begin
    res.send_valid    = acted && (phase_d != PH_IDLE);
    res.send_byte     = res.send_valid ? emit_byte : 8'h00;
    res.select_active = select_d;
    res.fast_clock    = clock_fast_d;
    res.read_valid    = rd_valid;
    res.read_data     = rd_valid ? received_byte : 8'h00;
    res.done_res      = op_done;
    res.failed        = op_done & op_failed;
    res.high_capacity = capacity_d;
  end

  // Steer results into the output register or the skid entry
  assign load_out  = in_fire & (~out_valid_q | out_fire);
  assign load_skid = in_fire & out_valid_q & ~out_fire;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    if (out_fire) begin
      out_valid_d  = skid_valid_q;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
    if (load_skid) begin
      skid_valid_d = 1'b1;
    end
  end

  // Control and sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_count_q  <= '0;
      opcode_q      <= '0;
      argument_q    <= '0;
      crc_q         <= '0;
      version_two_q <= 1'b0;
      capacity_q    <= 1'b0;
      select_q      <= 1'b0;
      clock_fast_q  <= 1'b0;
      ocr_top_q     <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q       <= phase_d;
        byte_count_q  <= byte_count_d;
        opcode_q      <= opcode_d;
        argument_q    <= argument_d;
        crc_q         <= crc_d;
        version_two_q <= version_two_d;
        capacity_q    <= capacity_d;
        select_q      <= select_d;
        clock_fast_q  <= clock_fast_d;
        ocr_top_q     <= ocr_top_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_skid) begin
      skid_q <= res;
    end
  end

  // Drive the output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.done_res;
  assign m_axis_tdata  = {2'b00, out_q.high_capacity, out_q.failed, out_q.read_data,
                          out_q.read_valid, out_q.fast_clock, out_q.select_active,
                          out_q.send_byte, out_q.send_valid};

`ifndef NO_ASSERTIONS
  // A waiting skid entry always sits behind a valid output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a valid output register");

  // The fast clock is switched on only by a finished init
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(clock_fast_q) |-> (phase_q == PH_IDLE))
    else $error("fast clock enabled outside a completed init");

  // Chip select stays high while the wake bytes are sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAKE) |-> !select_q)
    else $error("card selected during wake bytes");

  // A delivered block byte always comes with another exchange due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_valid) |-> out_q.send_valid)
    else $error("read byte without a following exchange");

  // An ending operation asks for no further exchange and releases the card
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (!out_q.send_valid && !out_q.select_active))
    else $error("operation end with exchange due or card selected");
`endif

endmodule

`default_nettype wire
